/* sv/dgcd_pkg.sv */
// ----------------------------------------------------------------------------
// dgcd_pkg
// Shared types and constants of the directed graph cycle detector.
// ----------------------------------------------------------------------------
package dgcd_pkg;

  localparam int MaxNodes  = 256;
  localparam int MaxEdges  = 1024;
  localparam int NodeW     = 8;
  localparam int EdgeAw    = 10;
  localparam int EdgeCntW  = 11;
  localparam int DepthW    = 9;

  // register byte addresses
  localparam logic [1:0] RegHighestNode = 2'd0;

  typedef struct packed {
    logic [NodeW-1:0] src_node;
    logic [NodeW-1:0] dst_node;
    logic             edge_valid;
    logic             last_edge;
  } req_t;

  typedef struct packed {
    logic cycle_found;
    logic edges_overflowed;
    logic node_out_of_range;
  } result_t;

endpackage

/* sv/directed_graph_cycle_detector_core.sv */
// ----------------------------------------------------------------------------
// directed_graph_cycle_detector_core
// Loads directed edges and searches the graph for a cycle on the last request.
// ----------------------------------------------------------------------------
// A request without the last mark is taken back to back while the core is not
// busy; a last request starts the search, whose length grows with the start
// nodes tried, the edges examined and the nodes pushed (edge scans up to
// nodes*edges), set by the single read port of the edge store.
// One request at a time; busy stays high until the search and mark clear end.
// Reset: synchronous, active high; clears count, flags and, in a clear pass
// after reset and after each result, the visited and on-path marks.
module directed_graph_cycle_detector_core
  import dgcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [NodeW-1:0]    highest_node;
  logic [EdgeCntW-1:0] edge_count;
  logic                overflow_flag, range_flag;
  logic                searching, kick, done, found, in_range, wr_en, accept;
  logic                search_idle;

  assign pready = 1'b1;
  assign prdata = (paddr == RegHighestNode) ? {24'd0, highest_node} : 32'd0;

  // register write
  always_ff @(posedge clk) begin
    if (rst) highest_node <= 8'd255;
    else if (psel && penable && pwrite && paddr == RegHighestNode)
      highest_node <= pwdata[7:0];
  end

  assign accept   = start && !busy;
  assign in_range = req.src_node <= highest_node && req.dst_node <= highest_node;
  assign wr_en    = accept && req.edge_valid && in_range
                    && edge_count != EdgeCntW'(MaxEdges);

  // busy also covers the clear pass that runs after reset and after each result
  assign busy = searching || kick || !search_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0; overflow_flag <= 1'b0; range_flag <= 1'b0;
      searching <= 1'b0; kick <= 1'b0; result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      kick <= 1'b0;
      if (wr_en) edge_count <= edge_count + 1'b1;
      if (accept && req.edge_valid) begin
        if (!in_range) range_flag <= 1'b1;
        else if (edge_count == EdgeCntW'(MaxEdges)) overflow_flag <= 1'b1;
      end
      if (accept && req.last_edge) begin
        kick <= 1'b1; searching <= 1'b1;
      end
      if (searching && done) begin
        searching <= 1'b0;
        result_valid <= 1'b1;
        result.cycle_found <= found;
        result.edges_overflowed <= overflow_flag;
        result.node_out_of_range <= range_flag;
        edge_count <= '0; overflow_flag <= 1'b0; range_flag <= 1'b0;
      end
    end
  end

  dgcd_search u_search (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_src(req.src_node),
    .wr_dst(req.dst_node), .edge_count(edge_count), .limit(highest_node),
    .go(kick), .done(done), .found(found), .idle(search_idle)
  );

endmodule

/* sv/dgcd_search.sv */
// ----------------------------------------------------------------------------
// dgcd_search
// Edge store and depth-first search engine with an explicit stack.
// ----------------------------------------------------------------------------
module dgcd_search
  import dgcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [NodeW-1:0]   wr_src,
  input  logic [NodeW-1:0]   wr_dst,
  input  logic [EdgeCntW-1:0] edge_count,
  input  logic [NodeW-1:0]   limit,
  input  logic               go,
  output logic               done,
  output logic               found,
  output logic               idle
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_VREAD = 4'd3;
  localparam logic [3:0] S_PUSH0 = 4'd4;
  localparam logic [3:0] S_TOP   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_EDGE  = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_TEST  = 4'd10;
  localparam logic [3:0] S_POP   = 4'd11;

  logic [NodeW-1:0]    src_mem [MaxEdges];
  logic [NodeW-1:0]    dst_mem [MaxEdges];
  logic [NodeW-1:0]    stk_node [MaxNodes];
  logic [EdgeCntW-1:0] stk_cur  [MaxNodes];
  // marks: bit 1 visited, bit 0 on path
  logic [1:0]          mark_mem [MaxNodes];

  logic [3:0]          state;
  logic [DepthW-1:0]   depth;
  logic [NodeW-1:0]    start;
  logic [NodeW-1:0]    node;
  logic [NodeW-1:0]    nxt;
  logic [EdgeCntW-1:0] cur;
  logic [NodeW:0]      clr;
  logic                res;

  // memory read data
  logic [NodeW-1:0]    src_q, dst_q, stk_node_q;
  logic [EdgeCntW-1:0] stk_cur_q;
  logic [1:0]          mark_q;

  // memory ports
  logic [EdgeAw-1:0]   e_ra;
  logic [NodeW-1:0]    s_ra, m_ra;
  logic                s_we, m_we;
  logic [NodeW-1:0]    s_wa, m_wa;
  logic [NodeW-1:0]    s_wnode;
  logic [EdgeCntW-1:0] s_wcur;
  logic [1:0]          m_wd;

  assign done  = (state == S_DONE);
  assign idle  = (state == S_IDLE);
  assign found = res;
  assign e_ra  = cur[EdgeAw-1:0];
  assign s_ra  = depth[NodeW-1:0] - 1'b1;

  // edge store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      src_mem[edge_count[EdgeAw-1:0]] <= wr_src;
      dst_mem[edge_count[EdgeAw-1:0]] <= wr_dst;
    end
    src_q <= src_mem[e_ra];
    dst_q <= dst_mem[e_ra];
  end

  // stack
  always_ff @(posedge clk) begin
    if (s_we) begin
      stk_node[s_wa] <= s_wnode;
      stk_cur[s_wa]  <= s_wcur;
    end
    stk_node_q <= stk_node[s_ra];
    stk_cur_q  <= stk_cur[s_ra];
  end

  // marks
  always_ff @(posedge clk) begin
    if (m_we) mark_mem[m_wa] <= m_wd;
    mark_q <= mark_mem[m_ra];
  end

  // control
  always_comb begin
    s_we = 1'b0; s_wa = s_ra; s_wnode = node; s_wcur = cur;
    m_we = 1'b0; m_wa = node; m_wd = 2'b00;
    m_ra = start;
    unique case (state)
      S_CLEAR: begin
        m_we = 1'b1; m_wa = clr[NodeW-1:0]; m_wd = 2'b00;
      end
      S_PUSH0: begin
        m_we = 1'b1; m_wa = start; m_wd = 2'b11;
        s_we = 1'b1; s_wa = '0; s_wnode = start; s_wcur = '0;
      end
      S_SCAN: begin
        if (cur >= edge_count) begin
          m_we = 1'b1; m_wa = node; m_wd = 2'b10;
        end
      end
      S_EDGE: begin
        // save advanced cursor of the top entry, look up the neighbour
        m_ra = nxt;
        s_we = 1'b1; s_wa = s_ra; s_wnode = node; s_wcur = cur;
      end
      S_MARK: begin
        if (!mark_q[1] && depth != DepthW'(MaxNodes)) begin
          m_we = 1'b1; m_wa = nxt; m_wd = 2'b11;
          s_we = 1'b1; s_wa = depth[NodeW-1:0]; s_wnode = nxt; s_wcur = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      res   <= 1'b0;
      depth <= '0;
      start <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (go) begin
          state <= S_START; start <= '0; res <= 1'b0; depth <= '0;
        end
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (NodeW+1)'(MaxNodes-1)) state <= S_IDLE;
        end
        S_START: state <= S_VREAD;
        S_VREAD: begin
          if (mark_q[1]) begin
            if (start == limit) state <= S_DONE;
            else begin
              start <= start + 1'b1; state <= S_START;
            end
          end else state <= S_PUSH0;
        end
        S_PUSH0: begin
          depth <= 9'd1; node <= start; cur <= '0; state <= S_SCAN;
        end
        S_POP: state <= S_TOP;
        S_TOP: begin
          // stack top data is valid here
          node <= stk_node_q; cur <= stk_cur_q; state <= S_SCAN;
        end
        S_SCAN: begin
          if (cur >= edge_count) begin
            depth <= depth - 1'b1;
            if (depth == 9'd1) begin
              if (start == limit) state <= S_DONE;
              else begin
                start <= start + 1'b1; state <= S_START;
              end
            end else state <= S_POP;
          end else state <= S_TEST;
        end
        S_TEST: begin
          // edge at cur is on the read port here
          cur <= cur + 1'b1;
          if (src_q == node) begin
            nxt <= dst_q; state <= S_EDGE;
          end else state <= S_SCAN;
        end
        S_EDGE: state <= S_MARK;
        S_MARK: begin
          if (!mark_q[1]) begin
            if (depth != DepthW'(MaxNodes)) begin
              depth <= depth + 1'b1;
              node  <= nxt;
              cur   <= '0;
            end
            state <= S_SCAN;
          end else if (mark_q[0]) begin
            res <= 1'b1; state <= S_DONE;
          end else state <= S_SCAN;
        end
        S_DONE: begin clr <= '0; state <= S_CLEAR; end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/tb_directed_graph_cycle_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_directed_graph_cycle_detector_core
// Feeds directed edges and closing requests into the cycle detector, keeps
// its own depth-first search over a copy of the edge store and compares every
// result (cycle, overflow and range flags) with the predicted one, in order.
// ----------------------------------------------------------------------------
module tb_directed_graph_cycle_detector_core;
  import dgcd_pkg::*;

  localparam int CycleLimit = 6000000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        result_valid;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  directed_graph_cycle_detector_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // predictor state: edge store, marks and search stack
  logic [NodeW-1:0] pred_src [MaxEdges];
  logic [NodeW-1:0] pred_dst [MaxEdges];
  int               pred_count;
  bit               pred_visited [MaxNodes];
  bit               pred_on_path [MaxNodes];
  int               stack_node [MaxNodes];
  int               stack_cursor [MaxNodes];
  bit               pred_overflow;
  bit               pred_range;
  logic [NodeW-1:0] pred_highest;

  req_t    pending_reqs [$];
  result_t expected_results [$];
  bit      failed;
  bit      quiet;
  bit      req_taken;
  int      gap_left;
  int      cycles;
  int      edges_sent;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // search from one start node, true when an edge reaches the current path
  function automatic bit search_cycle_from(int root);
    int depth;
    int top;
    int node;
    int e;
    int nxt;
    depth = 1;
    pred_visited[root] = 1'b1;
    pred_on_path[root] = 1'b1;
    stack_node[0] = root;
    stack_cursor[0] = 0;
    while (depth > 0) begin
      top = depth - 1;
      node = stack_node[top];
      e = stack_cursor[top];
      while (e < pred_count && pred_src[e] != node) e++;
      if (e >= pred_count) begin
        pred_on_path[node] = 1'b0;
        depth--;
      end else begin
        stack_cursor[top] = e + 1;
        nxt = pred_dst[e];
        if (!pred_visited[nxt]) begin
          if (depth < MaxNodes) begin
            pred_visited[nxt] = 1'b1;
            pred_on_path[nxt] = 1'b1;
            stack_node[depth] = nxt;
            stack_cursor[depth] = 0;
            depth++;
          end
        end else if (pred_on_path[nxt]) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted request to the predictor
  function automatic void predict_graph_request(req_t r);
    result_t res;
    bit      found;
    if (r.edge_valid) begin
      if (r.src_node > pred_highest || r.dst_node > pred_highest) begin
        pred_range = 1'b1;
      end else if (pred_count >= MaxEdges) begin
        pred_overflow = 1'b1;
      end else begin
        pred_src[pred_count] = r.src_node;
        pred_dst[pred_count] = r.dst_node;
        pred_count++;
      end
    end
    if (r.last_edge) begin
      found = 1'b0;
      for (int s = 0; s <= int'(pred_highest) && !found; s++) begin
        if (!pred_visited[s]) found = search_cycle_from(s);
      end
      res.cycle_found = found;
      res.edges_overflowed = pred_overflow;
      res.node_out_of_range = pred_range;
      expected_results = {expected_results, res};
      for (int n = 0; n < MaxNodes; n++) begin
        pred_visited[n] = 1'b0;
        pred_on_path[n] = 1'b0;
      end
      pred_count = 0;
      pred_overflow = 1'b0;
      pred_range = 1'b0;
    end
  endfunction

  // monitor: check results, then record the accepted request
  always @(posedge clk) begin
    result_t exp_res;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("tb_directed_graph_cycle_detector_core NOT OK");
      $finish;
    end
    req_taken = 1'b0;
    if (!rst) begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %b", $time, result);
          failed = 1'b1;
        end else begin
          exp_res = expected_results.pop_front();
          if (result.cycle_found !== exp_res.cycle_found) begin
            $display("%0t: cycle_found expected %b actual %b", $time,
                     exp_res.cycle_found, result.cycle_found);
            failed = 1'b1;
          end
          if (result.edges_overflowed !== exp_res.edges_overflowed) begin
            $display("%0t: edges_overflowed expected %b actual %b", $time,
                     exp_res.edges_overflowed, result.edges_overflowed);
            failed = 1'b1;
          end
          if (result.node_out_of_range !== exp_res.node_out_of_range) begin
            $display("%0t: node_out_of_range expected %b actual %b", $time,
                     exp_res.node_out_of_range, result.node_out_of_range);
            failed = 1'b1;
          end
        end
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        predict_graph_request(req);
      end
    end
  end

  // driver: one request at a time from the pending queue, random idle bursts
  always @(negedge clk) begin
    bit   next_start;
    req_t next_req;
    next_start = start;
    next_req = req;
    if (rst) begin
      next_start = 1'b0;
    end else if (!start || req_taken) begin
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        next_start = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 11);
      end
    end
    start <= next_start;
    req <= next_req;
  end

  task automatic write_highest_node(logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= RegHighestNode;
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pred_highest = value;
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic push_request(int s, int d, bit v, bit l);
    req_t r;
    r.src_node = s[7:0];
    r.dst_node = d[7:0];
    r.edge_valid = v;
    r.last_edge = l;
    pending_reqs = {pending_reqs, r};
    if (v || l) edges_sent++;
  endtask

  // one random graph over nodes 0..span with a few stray requests
  task automatic queue_random_graph(int span);
    int n_edges;
    int s;
    int d;
    int t;
    bit acyclic;
    n_edges = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 7);
    acyclic = $urandom_range(0, 1);
    for (int i = 0; i <= n_edges; i++) begin
      s = $urandom_range(0, span);
      d = $urandom_range(0, span);
      if (acyclic) begin
        if (s > d) begin
          t = s;
          s = d;
          d = t;
        end
        if (s == d && d < span) d++;
      end
      if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 255);
      if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 255);
      if ($urandom_range(0, 9) == 0) push_request($urandom, $urandom, 1'b0, 1'b0);
      if (i == n_edges) push_request(s, d, $urandom_range(0, 1), 1'b1);
      else push_request(s, d, 1'b1, 1'b0);
    end
  endtask

  task automatic run_random(int target, int span);
    int goal;
    goal = edges_sent + target;
    while (edges_sent < goal) begin
      queue_random_graph(span);
      while (pending_reqs.size() > 20) @(posedge clk);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failed = 1'b0;
    quiet = 1'b0;
    gap_left = 0;
    cycles = 0;
    edges_sent = 0;
    pred_count = 0;
    pred_overflow = 1'b0;
    pred_range = 1'b0;
    pred_highest = 8'd255;
    for (int n = 0; n < MaxNodes; n++) begin
      pred_visited[n] = 1'b0;
      pred_on_path[n] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty graph, no-op request, self loops, chain, two-node loop
    push_request(0, 0, 1'b0, 1'b1);
    push_request(9, 4, 1'b0, 1'b0);
    push_request(5, 5, 1'b1, 1'b1);
    push_request(255, 255, 1'b1, 1'b1);
    push_request(0, 1, 1'b1, 1'b0);
    push_request(1, 2, 1'b1, 1'b0);
    push_request(0, 255, 1'b1, 1'b1);
    push_request(170, 85, 1'b1, 1'b0);
    push_request(85, 170, 1'b1, 1'b1);
    push_request(3, 0, 1'b1, 1'b0);
    push_request(0, 3, 1'b0, 1'b1);
    run_random(100, 255);
    wait_drained();

    // store overflow: highest node zero keeps the search short
    write_highest_node(8'd0);
    for (int i = 0; i < MaxEdges + 2; i++) push_request(0, 0, 1'b1, 1'b0);
    push_request(1, 0, 1'b1, 1'b1);
    push_request(0, 0, 1'b1, 1'b1);
    push_request(0, 1, 1'b1, 1'b1);
    wait_drained();

    // highest node lowered while edges are loaded: stored edges still followed
    write_highest_node(8'd255);
    push_request(0, 100, 1'b1, 1'b0);
    push_request(100, 200, 1'b1, 1'b0);
    push_request(200, 0, 1'b1, 1'b0);
    wait_drained();
    write_highest_node(8'd2);
    push_request(2, 1, 1'b1, 1'b1);
    wait_drained();

    // small node range with frequent out-of-range edges
    write_highest_node(8'd7);
    push_request(8, 0, 1'b1, 1'b0);
    push_request(0, 255, 1'b1, 1'b1);
    run_random(150, 7);
    wait_drained();

    write_highest_node(8'd31);
    run_random(100, 31);
    wait_drained();

    // final stretch without idle bursts
    write_highest_node(8'd255);
    quiet = 1'b1;
    run_random(100, 40);
    wait_drained();

    if (!failed) begin
      $display("tb_directed_graph_cycle_detector_core OK");
    end else begin
      $display("tb_directed_graph_cycle_detector_core NOT OK");
    end
    $finish;
  end

endmodule
